// File: sv/xbd_pkg.sv
// ----------------------------------------------------------------------------
// xbd_pkg
// Shared constants, stage record and helpers for the XTEA block decrypter.
// ----------------------------------------------------------------------------
`default_nettype none

package xbd_pkg;

    localparam int ROUNDS     = 32;
    // one register stage per half round
    localparam int NUM_STAGES = 2 * ROUNDS;

    localparam logic [31:0] XTEA_DELTA = 32'h9E3779B9;
    localparam logic [31:0] KEY_MIX1   = 32'hDEADBEEF;
    localparam logic [31:0] KEY_MIX2   = 32'hCAFEBABE;
    localparam logic [31:0] KEY_MIX3   = 32'hFEEDFACE;

    localparam logic [3:0] FULL_COUNT = 4'd8;

    typedef enum logic [1:0] {
        KEY_W0 = 2'd0,
        KEY_W1 = 2'd1,
        KEY_W2 = 2'd2,
        KEY_W3 = 2'd3
    } t_key_sel;

    typedef struct packed {
        logic        valid;
        logic        full;   // eight bytes: XTEA, else tail already masked
        logic [3:0]  count;
        logic [31:0] v1;
        logic [31:0] v0;
    } t_stage;

    // Running sum seen by half-round stage s (even: before the delta step,
    // odd: after it).
    function automatic logic [31:0] xbd_stage_sum(input int s);
        logic [31:0] steps;
        steps = 32'(ROUNDS - (s / 2) - (s % 2));
        return XTEA_DELTA * steps;
    endfunction

    function automatic logic [31:0] xbd_key_word(input logic [31:0] mkey,
                                                 input logic [1:0]  idx);
        logic [31:0] w;
        case (t_key_sel'(idx))
            KEY_W0:  w = mkey;
            KEY_W1:  w = mkey ^ KEY_MIX1;
            KEY_W2:  w = mkey ^ KEY_MIX2;
            KEY_W3:  w = mkey ^ KEY_MIX3;
            default: w = mkey;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: sv/xbd_in_if.sv
// ----------------------------------------------------------------------------
// xbd_in_if
// Cipher block channel: valid/ready with block data and byte count.
// ----------------------------------------------------------------------------
`default_nettype none

interface xbd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_block;
    logic [3:0]  byte_count;

    modport source (output valid, output cipher_block, output byte_count, input ready);
    modport sink   (input valid, input cipher_block, input byte_count, output ready);
endinterface

`default_nettype wire

// File: sv/xbd_out_if.sv
// ----------------------------------------------------------------------------
// xbd_out_if
// Plain block channel: valid/ready with decrypted data and byte count.
// ----------------------------------------------------------------------------
`default_nettype none

interface xbd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_block;
    logic [3:0]  out_count;

    modport source (output valid, output plain_block, output out_count, input ready);
    modport sink   (input valid, input plain_block, input out_count, output ready);
endinterface

`default_nettype wire

// File: sv/xtea_block_decrypt.sv
// ----------------------------------------------------------------------------
// xtea_block_decrypt
// XTEA decryption of 8-byte blocks, key derived from one master key word;
// short tail blocks are XOR masked with the master key bytes.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-------------------------------------
//  i_in     | in  | valid / ready  | cipher_block[63:0], byte_count[3:0]
//  o_out    | out | valid / ready  | plain_block[63:0], out_count[3:0]
//  cfg      | in  | i_cfg_we       | i_cfg_wdata[31:0] (master key)
//
//  One half round per register stage, 2*ROUNDS stages; one block accepted
//  per cycle unless stalled. The last stage is the output register.
//  Reset clears the stage valid bits and the master key.
//  A stalled output freezes the whole pipe; i_in.ready follows o_out.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_block_decrypt import xbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    xbd_in_if.sink      i_in,
    xbd_out_if.source   o_out
);

    logic [31:0] r_mkey;
    logic [31:0] n_mkey;
    logic        w_adv;
    logic [3:0]  w_cnt;
    logic [63:0] w_tail;
    t_stage      w_entry;
    t_stage      w_stage [NUM_STAGES+1];

    // round key registers follow n_mkey, so it carries the reset value too
    always_comb begin
        if (!i_rst_n) begin
            n_mkey = '0;
        end else if (i_cfg_we) begin
            n_mkey = i_cfg_wdata;
        end else begin
            n_mkey = r_mkey;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mkey <= '0;
        end else begin
            r_mkey <= n_mkey;
        end
    end

    assign w_adv      = !w_stage[NUM_STAGES].valid || o_out.ready;
    assign i_in.ready = w_adv;

    // counts above eight saturate; tail bytes take key bytes from the top
    always_comb begin
        w_cnt = i_in.byte_count[3] ? FULL_COUNT : i_in.byte_count;
        for (int j = 0; j < 8; j++) begin
            if (4'(j) < w_cnt) begin
                w_tail[8*j +: 8] = i_in.cipher_block[8*j +: 8]
                                 ^ r_mkey[24 - 8*(j % 4) +: 8];
            end else begin
                w_tail[8*j +: 8] = 8'h00;
            end
        end
        w_entry.valid = i_in.valid;
        w_entry.full  = i_in.byte_count[3];
        w_entry.count = w_cnt;
        if (i_in.byte_count[3]) begin
            w_entry.v1 = i_in.cipher_block[63:32];
            w_entry.v0 = i_in.cipher_block[31:0];
        end else begin
            w_entry.v1 = w_tail[63:32];
            w_entry.v0 = w_tail[31:0];
        end
    end

    assign w_stage[0] = w_entry;

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        localparam logic [31:0] STAGE_SUM = xbd_stage_sum(s);
        localparam logic        STAGE_ODD = 1'(s % 2);

        xbd_round u_round (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_adv),
            .i_odd      (STAGE_ODD),
            .i_sum      (STAGE_SUM),
            .i_mkey_nxt (n_mkey),
            .i_stage    (w_stage[s]),
            .o_stage    (w_stage[s+1])
        );
    end

    assign o_out.valid       = w_stage[NUM_STAGES].valid;
    assign o_out.plain_block = {w_stage[NUM_STAGES].v1, w_stage[NUM_STAGES].v0};
    assign o_out.out_count   = w_stage[NUM_STAGES].count;

endmodule

`default_nettype wire

// File: sv/xbd_round.sv
// ----------------------------------------------------------------------------
// xbd_round
// One XTEA half round with its output register and round key register.
// ----------------------------------------------------------------------------
`default_nettype none

module xbd_round import xbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_odd,
    input  logic [31:0] i_sum,
    input  logic [31:0] i_mkey_nxt,
    input  t_stage      i_stage,
    output t_stage      o_stage
);

    logic [31:0] r_rkey;
    logic [31:0] n_rkey;
    logic [1:0]  w_kidx;
    logic [31:0] w_src;
    logic [31:0] w_dst;
    logic [31:0] w_mix;
    logic [31:0] w_res;
    t_stage      r_stage;
    t_stage      n_stage;

    // sum + key word is fixed per stage; fed from the next master key value
    // so it is current on the cycle after a write
    always_comb begin
        w_kidx = i_odd ? i_sum[1:0] : i_sum[12:11];
        n_rkey = i_sum + xbd_key_word(i_mkey_nxt, w_kidx);
    end

    always_comb begin
        w_src = i_odd ? i_stage.v1 : i_stage.v0;
        w_dst = i_odd ? i_stage.v0 : i_stage.v1;
        w_mix = (((w_src << 4) ^ (w_src >> 5)) + w_src) ^ r_rkey;
        w_res = w_dst - w_mix;
        n_stage = i_stage;
        if (i_stage.full) begin
            if (i_odd) begin
                n_stage.v0 = w_res;
            end else begin
                n_stage.v1 = w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rkey <= n_rkey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

// File: sv/xbd_chk.sv
// ----------------------------------------------------------------------------
// xbd_chk
// Port level checks for the XTEA block decrypter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xbd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_plain_block,
    input logic [3:0]  i_out_count
);

    // pending result waits unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_plain_block) && $stable(i_out_count))
        else $error("result changed while stalled");

    // no transfer is left outstanding straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

    // pipe only refuses input while its output is stalled
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input refused without output stall");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_count <= 4'd8)
        else $error("count above eight");

    // tail bytes past the count are zero
    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_count < 4'd8 |->
            (i_plain_block >> {i_out_count[2:0], 3'b000}) == 64'd0)
        else $error("unused tail bytes not zero");

endmodule

bind xtea_block_decrypt xbd_chk u_xbd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_plain_block (o_out.plain_block),
    .i_out_count   (o_out.out_count)
);

`default_nettype wire

// File: test/xtea_decrypt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xtea_decrypt_checker
// Watches both block channels and the key write port. It predicts the plain
// block for every cipher block transfer and compares the results in order.
// ----------------------------------------------------------------------------

module xtea_decrypt_checker import xbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    xbd_in_if           i_in_mon,
    xbd_out_if          i_out_mon,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [63:0] plain;
        logic [3:0]  count;
    } t_plain_result;

    t_plain_result plain_expected_q[$];
    logic [31:0]   master_key;
    int            fails = 0;

    function automatic logic [63:0] xtea_decipher(input logic [63:0] blk,
                                                  input logic [31:0] mk);
        logic [3:0][31:0] key;
        logic [31:0]      v0;
        logic [31:0]      v1;
        logic [31:0]      sum;
        key[0] = mk;
        key[1] = mk ^ KEY_MIX1;
        key[2] = mk ^ KEY_MIX2;
        key[3] = mk ^ KEY_MIX3;
        v0     = blk[31:0];
        v1     = blk[63:32];
        sum    = XTEA_DELTA * 32'(ROUNDS);
        for (int r = 0; r < ROUNDS; r++) begin
            v1  = v1 - ((((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key[sum[12:11]]));
            sum = sum - XTEA_DELTA;
            v0  = v0 - ((((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key[sum[1:0]]));
        end
        return {v1, v0};
    endfunction

    // counts above eight saturate to a full block; short tails are masked
    // with the key bytes, most significant byte first
    function automatic t_plain_result predict_plain(input logic [63:0] blk,
                                                    input logic [3:0]  cnt,
                                                    input logic [31:0] mk);
        t_plain_result res;
        res = '0;
        if (cnt >= FULL_COUNT) begin
            res.plain = xtea_decipher(blk, mk);
            res.count = FULL_COUNT;
        end else begin
            for (int j = 0; j < int'(cnt); j++)
                res.plain[8*j +: 8] = blk[8*j +: 8] ^ mk[8*(3 - j % 4) +: 8];
            res.count = cnt;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_plain_result exp_res;
        if (!i_rst_n) begin
            master_key = '0;
            plain_expected_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (plain_expected_q.size() == 0) begin
                    $error("unexpected plain block transfer: plain_block %h out_count %0d",
                           i_out_mon.plain_block, i_out_mon.out_count);
                    fails++;
                end else begin
                    exp_res = plain_expected_q.pop_front();
                    if (i_out_mon.plain_block !== exp_res.plain) begin
                        $error("plain_block: expected %h, actual %h",
                               exp_res.plain, i_out_mon.plain_block);
                        fails++;
                    end
                    if (i_out_mon.out_count !== exp_res.count) begin
                        $error("out_count: expected %0d, actual %0d",
                               exp_res.count, i_out_mon.out_count);
                        fails++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                plain_expected_q.push_back(predict_plain(i_in_mon.cipher_block,
                                                         i_in_mon.byte_count,
                                                         master_key));
            if (i_cfg_we)
                master_key = i_cfg_wdata;
        end
        o_fail_count <= fails;
        o_pending    <= plain_expected_q.size();
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives cipher blocks and master key settings into the XTEA decrypter with
// random idle cycles on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------

module testbench;
    import xbd_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int IDLE_PCT        = 26;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int STALL_CYCLES    = 300;
    localparam int PIPE_LATENCY    = 2 * ROUNDS;
    localparam int CYCLE_LIMIT     = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit tx_idling;
    bit rx_idling;
    int hold_request;
    int n_full;
    int n_tail;
    int n_odd;
    int n_keys;

    xbd_in_if  in_ch ();
    xbd_out_if out_ch ();

    xtea_block_decrypt uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    xtea_decrypt_checker plain_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d plain blocks outstanding",
                   cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // sink side: random back-pressure plus one long hold-off on request
    initial begin : sink_side
        int hold_left;
        bit hold_taken;
        hold_left    = 0;
        hold_taken   = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0 && !hold_taken) begin
                hold_left  = hold_request;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= !(rx_idling && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic send_block(input logic [63:0] blk, input logic [3:0] cnt);
        bit idle;
        do begin
            @(negedge i_clk);
            idle = tx_idling && ($urandom_range(99) < IDLE_PCT);
            if (idle)
                in_ch.valid <= 1'b0;
        end while (idle);
        in_ch.valid        <= 1'b1;
        in_ch.cipher_block <= blk;
        in_ch.byte_count   <= cnt;
        do @(posedge i_clk); while (!in_ch.ready);
        if (cnt == FULL_COUNT)
            n_full++;
        else if (cnt == 4'd0 || cnt > FULL_COUNT)
            n_odd++;
        else
            n_tail++;
    endtask

    task automatic send_random_block();
        int          pick;
        logic [63:0] blk;
        logic [3:0]  cnt;
        pick = $urandom_range(99);
        if (pick < 60)
            cnt = FULL_COUNT;
        else if (pick < 88)
            cnt = 4'($urandom_range(7, 1));
        else if (pick < 92)
            cnt = 4'd0;
        else
            cnt = 4'($urandom_range(15, 9));
        case ($urandom_range(15))
            0:       blk = '0;
            1:       blk = '1;
            default: blk = {$urandom, $urandom};
        endcase
        send_block(blk, cnt);
    endtask

    // stop offering blocks until every transfer so far has come out
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic set_master_key(input logic [31:0] key);
        cfg_we    <= 1'b1;
        cfg_wdata <= key;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        n_keys++;
    endtask

    initial begin
        logic [31:0] key;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.cipher_block = '0;
        in_ch.byte_count   = '0;
        tx_idling          = 1'b0;
        rx_idling          = 1'b0;
        hold_request       = 0;
        n_full             = 0;
        n_tail             = 0;
        n_odd              = 0;
        n_keys             = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // key still at its reset value
        send_block(64'h0, FULL_COUNT);
        send_block('1, 4'd4);

        wait_drained();
        set_master_key(32'h0123_4567);
        for (int c = 0; c < 16; c++)
            send_block(64'hF0E1_D2C3_B4A5_9687, 4'(c));
        send_block('0, FULL_COUNT);
        send_block('1, FULL_COUNT);
        send_block(64'hAAAA_AAAA_AAAA_AAAA, FULL_COUNT);
        send_block(64'h5555_5555_5555_5555, FULL_COUNT);
        send_block('1, 4'd7);
        send_block('1, 4'd1);
        send_block(64'h0000_0000_FFFF_FFFF, 4'd4);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       key = 32'hFFFF_FFFF;
                1:       key = 32'h0000_0000;
                2:       key = 32'h8000_0001;
                default: key = $urandom;
            endcase
            set_master_key(key);
            // one phase runs flat out on both sides
            tx_idling = (ph != 2);
            rx_idling = (ph != 2);
            if (ph == 4)
                hold_request = STALL_CYCLES;
            repeat (ITEMS_PER_PHASE) send_random_block();
        end

        wait_drained();
        repeat (PIPE_LATENCY + 16) @(negedge i_clk);

        $display("Sent %0d blocks: %0d full XTEA, %0d masked tails, %0d with count 0 or above 8",
                 n_full + n_tail + n_odd, n_full, n_tail, n_odd);
        $display("Used %0d master key settings, a %0d-cycle output hold-off and drained pauses",
                 n_keys, STALL_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (pending != 0)
                $error("%0d plain blocks never came out", pending);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/xbd_pkg.sv
sv/xbd_in_if.sv
sv/xbd_out_if.sv
sv/xbd_round.sv
sv/xtea_block_decrypt.sv
sv/xbd_chk.sv
test/xtea_decrypt_checker.sv
test/testbench.sv
